// File: sv/glu_pkg.sv
package glu_pkg;
  localparam int DATA_WIDTH = 64;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic {
    REQ_GCD = 1'b0,
    REQ_LCM = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_QUOT,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  start;
    data_t num;
    data_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t q;
    data_t r;
  } div_rsp_t;
endpackage

// File: sv/glu_if.sv
interface glu_in_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [63:0]            operand_a;
  logic [63:0]            operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface glu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        overflow;
  modport source (output valid, result_value, overflow, input ready);
  modport sink (input valid, result_value, overflow, output ready);
endinterface

// File: sv/glu_div.sv
// restoring divider, one quotient bit per cycle
module glu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  glu_pkg::div_req_t req,
  output glu_pkg::div_rsp_t rsp
);
  import glu_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  data_t            q_r, q_nxt;
  data_t            rem_r, rem_nxt;
  data_t            den_r, den_nxt;
  logic             done_r, done_nxt;
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, q_r[DATA_WIDTH-1]};
    trial    = shifted - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_WIDTH);
      q_nxt    = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (!trial[DATA_WIDTH]) begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        q_nxt   = {q_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_WIDTH-1:0];
        q_nxt   = {q_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.r    = rem_r;
endmodule

// File: sv/glu_mul.sv
// shift-add multiplier with overflow detect, one multiplier bit per cycle
module glu_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  glu_pkg::data_t mcand,
  input  glu_pkg::data_t mplier,
  output logic          done,
  output glu_pkg::data_t prod,
  output logic          ovf
);
  import glu_pkg::*;

  logic             busy_r, done_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  data_t            acc_r, mc_r, mp_r;
  logic [DATA_WIDTH:0] sum;

  assign sum = {1'b0, acc_r} + {1'b0, mc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      acc_r <= '0;
      mc_r  <= mcand;
      mp_r  <= mplier;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      // MSB-first: acc = 2*acc + bit*mc
      if (acc_r[DATA_WIDTH-1]) ovf_r <= 1'b1;
      if (mp_r[DATA_WIDTH-1]) begin
        if (sum[DATA_WIDTH] || acc_r[DATA_WIDTH-1]) ovf_r <= 1'b1;
        acc_r <= {acc_r[DATA_WIDTH-2:0], 1'b0} + mc_r;
        if (({1'b0, acc_r[DATA_WIDTH-2:0], 1'b0} + {1'b0, mc_r}) > {1'b0, {DATA_WIDTH{1'b1}}})
          ovf_r <= 1'b1;
      end else begin
        acc_r <= {acc_r[DATA_WIDTH-2:0], 1'b0};
      end
      mp_r <= {mp_r[DATA_WIDTH-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign ovf  = ovf_r;
endmodule

// File: sv/gcd_lcm_unit.sv
// gcd_lcm_unit: GCD or LCM of two unsigned 64-bit operands.
// in_ch (sink) carries req_type, operand_a, operand_b; out_ch (source)
// carries result_value and overflow. One result per transaction.
// in_ch.ready is high only when the unit is idle; a new transaction is
// taken once the previous result has left the output register.
// Every remainder step runs the bit-serial divider (start, 64 quotient
// bits, done); a GCD takes one divider run per Euclid step, at most about
// 93 steps for 64-bit operands. An LCM adds one quotient a/gcd on the
// divider and a shift-add multiply.
// The divider and the multiplier set the rate: one bit per cycle each.
// LCM saturates to all ones with overflow set when the product exceeds
// 64 bits; LCM with a zero operand gives 0.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// any pending result. While out_ch.ready is low the result stays valid
// and stable, and no new input is taken.
module gcd_lcm_unit (
  input logic clk,
  input logic rst_n,
  glu_in_if.sink    in_ch,
  glu_out_if.source out_ch
);
  import glu_pkg::*;

  state_t   state_r, state_nxt;
  req_t     kind_r, kind_nxt;
  data_t    a_r, a_nxt, b_r, b_nxt, oa_r, oa_nxt, ob_r, ob_nxt;
  data_t    res_r, res_nxt;
  logic     ovf_r, ovf_nxt;
  logic     wait_r, wait_nxt;
  div_req_t dreq;
  div_rsp_t drsp;
  logic     mstart, mdone, movf;
  data_t    mprod;

  glu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  glu_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .mcand(drsp.q),
                 .mplier(ob_r), .done(mdone), .prod(mprod), .ovf(movf));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    a_nxt = a_r; b_nxt = b_r; oa_nxt = oa_r; ob_nxt = ob_r;
    res_nxt = res_r; ovf_nxt = ovf_r; wait_nxt = wait_r;
    dreq = '{start: 1'b0, num: a_r, den: b_r};
    mstart = 1'b0;
    in_ch.ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = req_t'(in_ch.req_type);
          a_nxt = in_ch.operand_a; oa_nxt = in_ch.operand_a;
          b_nxt = in_ch.operand_b; ob_nxt = in_ch.operand_b;
          wait_nxt = 1'b0;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!wait_r) begin
          if (kind_r == REQ_LCM && (oa_r == '0 || ob_r == '0)) begin
            res_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_DONE;
          end else if (b_r == '0) begin
            if (kind_r == REQ_GCD) begin
              res_nxt = a_r; ovf_nxt = 1'b0; state_nxt = ST_DONE;
            end else begin
              dreq = '{start: 1'b1, num: oa_r, den: a_r};
              wait_nxt = 1'b1;
              state_nxt = ST_QUOT;
            end
          end else begin
            dreq.start = 1'b1;
            wait_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          a_nxt = b_r; b_nxt = drsp.r; wait_nxt = 1'b0;
        end
      end
      ST_QUOT: begin
        if (drsp.done) begin
          a_nxt = drsp.q; mstart = 1'b1; state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mdone) begin
          res_nxt = movf ? '1 : mprod; ovf_nxt = movf; state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
    kind_r <= kind_nxt;
    a_r <= a_nxt; b_r <= b_nxt; oa_r <= oa_nxt; ob_r <= ob_nxt;
    res_r <= res_nxt; ovf_r <= ovf_nxt;
  end

  assign out_ch.valid        = (state_r == ST_DONE);
  assign out_ch.result_value = res_r;
  assign out_ch.overflow     = ovf_r;

`ifndef ASSERT_OFF
  a_gcd_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && kind_r == REQ_GCD |-> !out_ch.overflow)
    else $error("gcd result flagged overflow");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |-> out_ch.result_value == '1)
    else $error("overflow without saturation");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_value))
    else $error("result dropped while stalled");
`endif
endmodule

// File: tb/sv/tb.sv
module tb;
  import glu_pkg::*;

  typedef struct packed {
    req_t  kind;
    data_t a;
    data_t b;
  } req_item_t;

  typedef struct packed {
    data_t value;
    logic  ovf;
  } res_item_t;

  logic clk;
  logic rst_n;
  glu_in_if  in_ch ();
  glu_out_if out_ch ();

  gcd_lcm_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  req_item_t pending_q[$];
  res_item_t expected_q[$];
  int        err_cnt = 0;
  int        hold_cnt;
  int        sink_hold;
  bit        stim_done = 1'b0;
  bit        drain_req;
  longint    cyc = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic data_t euclid_gcd(data_t x, data_t y);
    data_t r;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic res_item_t predict_result(req_item_t it);
    res_item_t res;
    data_t     g;
    data_t     q;
    res.ovf = 1'b0;
    if (it.kind == REQ_GCD) begin
      res.value = euclid_gcd(it.a, it.b);
    end else if (it.a == '0 || it.b == '0) begin
      res.value = '0;
    end else begin
      g = euclid_gcd(it.a, it.b);
      q = it.a / g;
      if (q > ({DATA_WIDTH{1'b1}} / it.b)) begin
        res.value = '1;
        res.ovf   = 1'b1;
      end else begin
        res.value = q * it.b;
      end
    end
    return res;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  function automatic data_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic data_t rand_operand();
    case ($urandom_range(0, 7))
      0: return data_t'($urandom_range(0, 3));
      1: return data_t'($urandom_range(0, 1000));
      2: return data_t'($urandom());
      3: return rand_word() >> $urandom_range(0, 63);
      4: return '1 - data_t'($urandom_range(0, 2));
      default: return rand_word();
    endcase
  endfunction

  task automatic add_item(req_t k, data_t a, data_t b);
    req_item_t it;
    it.kind = k;
    it.a    = a;
    it.b    = b;
    pending_q.push_back(it);
  endtask

  initial begin
    req_item_t it;
    data_t     f;
    add_item(REQ_GCD, '0, '0);
    add_item(REQ_GCD, 64'd12, '0);
    add_item(REQ_GCD, '0, 64'd18);
    add_item(REQ_GCD, '1, '1);
    add_item(REQ_GCD, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    add_item(REQ_GCD, 64'd48, 64'd180);
    add_item(REQ_GCD, 64'hA000_0000_0000_0000, 64'h5000_0000_0000_0000);
    add_item(REQ_GCD, 64'd12200160415121876738, 64'd7540113804746346429);
    add_item(REQ_LCM, '0, 64'd5);
    add_item(REQ_LCM, 64'd5, '0);
    add_item(REQ_LCM, '0, '0);
    add_item(REQ_LCM, 64'd4, 64'd6);
    add_item(REQ_LCM, '1, '1);
    add_item(REQ_LCM, '1, 64'd1);
    add_item(REQ_LCM, '1, 64'd2);
    add_item(REQ_LCM, 64'h1_0000_0000, 64'hFFFF_FFFF);
    add_item(REQ_LCM, 64'h1_0000_0000, 64'h1_0000_0001);
    add_item(REQ_LCM, 64'h8000_0000_0000_0000, 64'd2);
    add_item(REQ_LCM, 64'h8000_0000_0000_0000, 64'd3);
    add_item(REQ_LCM, 64'd12200160415121876738, 64'd7540113804746346429);
    for (int i = 0; i < 1000; i++) begin
      it.kind = req_t'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        f    = rand_word() >> $urandom_range(20, 63);
        it.a = f * data_t'($urandom_range(1, 5000));
        it.b = f * data_t'($urandom_range(1, 5000));
      end else begin
        it.a = rand_operand();
        it.b = rand_operand();
      end
      pending_q.push_back(it);
      if (i == 400) pending_q.push_back('x);
    end
  end

  // driver; an all-x entry marks a drain point
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.req_type  <= 1'b0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
      hold_cnt        <= rand_gap();
      drain_req       <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (drain_req) begin
      in_ch.valid <= 1'b0;
      if (expected_q.size() == 0) drain_req <= 1'b0;
    end else if (hold_cnt > 0 && !(in_ch.valid && in_ch.ready)) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_result({in_ch.req_type, in_ch.operand_a,
                                             in_ch.operand_b}));
      end
      if (pending_q.size() > 0 && $isunknown(pending_q[0].a)) begin
        void'(pending_q.pop_front());
        in_ch.valid <= 1'b0;
        drain_req   <= 1'b1;
      end else if (pending_q.size() > 0 && hold_cnt == 0 &&
                   !(in_ch.valid && in_ch.ready && $urandom_range(0, 3) == 0)) begin
        {in_ch.req_type, in_ch.operand_a, in_ch.operand_b} <= pending_q.pop_front();
        in_ch.valid <= 1'b1;
        hold_cnt    <= rand_gap();
      end else begin
        in_ch.valid <= 1'b0;
        if (hold_cnt == 0) hold_cnt <= rand_gap();
        if (pending_q.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_item_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10) $display("unexpected transaction: value %h ovf %b",
                                     out_ch.result_value, out_ch.overflow);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.result_value !== exp_r.value || out_ch.overflow !== exp_r.ovf) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < 10)
              $display("mismatch: exp value %h ovf %b, got value %h ovf %b",
                       exp_r.value, exp_r.ovf, out_ch.result_value, out_ch.overflow);
          end
        end
      end
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold    <= sink_hold - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold <= rand_gap();
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_q.size() == 0) && cyc < 40_000_000) begin
      @(posedge clk);
      cyc++;
    end
    if (cyc >= 40_000_000) begin
      $display("gcd_lcm_unit test failed");
      $finish;
    end else begin
      repeat (20000) @(posedge clk);
      if (err_cnt == 0 && expected_q.size() == 0) begin
        $display("gcd_lcm_unit test passed");
      end else begin
        $display("gcd_lcm_unit test failed");
      end
      $finish;
    end
  end
endmodule
